// ----- rtl/rgaa_pkg.sv -----
package rgaa_pkg;

  // Field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned POT_W    = 9;
  localparam int unsigned NUM_W    = 24;
  localparam int unsigned PEAK_W   = IN_W + LEVEL_W;
  localparam int unsigned RECIP_W  = 21;
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned RPROD_W  = NUM_W + RECIP_W;

  // Levels in millivolts
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_MV  = 12'd3000;
  localparam logic [LEVEL_W-1:0] OVERLOAD_MV    = 12'd3200;
  localparam logic [LEVEL_W-1:0] NO_INPUT_MV    = 12'd40;
  localparam logic [LEVEL_W-1:0] WINDOW_LOW_MV  = 12'd1600;
  localparam logic [LEVEL_W-1:0] WINDOW_HIGH_MV = 12'd2400;
  localparam logic [LEVEL_W-1:0] ADC_SPAN_MV    = 12'd3300;

  // Pot code at full level
  localparam logic [POT_W-1:0] FULL_POT_CODE = 9'd256;

  // Divide by 3000: floor(x * RECIP / 2^32) is the quotient or one short
  localparam logic [RECIP_W-1:0] DIV_RECIP = 21'd1431655;
  localparam logic [NUM_W-1:0]   DIV_MV    = 24'd3000;

  typedef enum logic [2:0] {
    STAT_MANUAL        = 3'd0,
    STAT_NOT_PERMITTED = 3'd1,
    STAT_OVERLOAD      = 3'd2,
    STAT_NO_INPUT      = 3'd3,
    STAT_IN_WINDOW     = 3'd4,
    STAT_ADJUSTED      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_PEAK,
    CS_CLASS,
    CS_DIV_MUL,
    CS_DIV_FIX,
    CS_SCALE,
    CS_POT,
    CS_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic peak;
    logic classify;
    logic div_mul;
    logic div_fix;
    logic scale;
    logic pot;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic adjust;
  } dp_flags_t;

endpackage

// ----- rtl/rgaa_in_if.sv -----
interface rgaa_in_if;
  logic                        valid;
  logic                        ready;
  logic [rgaa_pkg::IN_W-1:0]   max_level;
  logic [rgaa_pkg::IN_W-1:0]   min_level;
  logic                        force_req;
  logic                        ok_to_adjust;

  modport source (output valid, max_level, min_level, force_req, ok_to_adjust,
                  input ready);
  modport sink (input valid, max_level, min_level, force_req, ok_to_adjust,
                output ready);
endinterface

// ----- rtl/rgaa_out_if.sv -----
interface rgaa_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [rgaa_pkg::LEVEL_W-1:0] level_mv;
  logic [rgaa_pkg::POT_W-1:0]   pot_code;
  logic                         pot_write;

  modport source (output valid, status, level_mv, pot_code, pot_write,
                  input ready);
  modport sink (input valid, status, level_mv, pot_code, pot_write,
                output ready);
endinterface

// ----- rtl/rgaa_datapath.sv -----
module rgaa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rgaa_pkg::dp_cmd_t            cmd,
  output rgaa_pkg::dp_flags_t          flags,
  input  logic                         cfg_we,
  input  logic [rgaa_pkg::LEVEL_W-1:0] cfg_wdata,
  input  logic [rgaa_pkg::IN_W-1:0]    max_level,
  input  logic [rgaa_pkg::IN_W-1:0]    min_level,
  input  logic                         force_req,
  input  logic                         ok_to_adjust,
  output logic [2:0]                   status,
  output logic [rgaa_pkg::LEVEL_W-1:0] level_mv,
  output logic [rgaa_pkg::POT_W-1:0]   pot_code,
  output logic                         pot_write
);

  logic [rgaa_pkg::LEVEL_W-1:0] manual_r;
  logic [rgaa_pkg::LEVEL_W-1:0] level_r;
  logic [rgaa_pkg::IN_W-1:0]    max_r;
  logic [rgaa_pkg::IN_W-1:0]    min_r;
  logic                         force_r;
  logic                         ok_r;
  logic [rgaa_pkg::LEVEL_W-1:0] pk_r;
  logic [rgaa_pkg::NUM_W-1:0]   num_r;
  logic [rgaa_pkg::LEVEL_W-1:0] q0_r;
  logic [rgaa_pkg::LEVEL_W-1:0] quot_r;
  rgaa_pkg::status_t            stat_r;
  logic                         wr_r;
  logic [rgaa_pkg::POT_W-1:0]   code_r;
  logic [2:0]                   out_status_r;
  logic [rgaa_pkg::LEVEL_W-1:0] out_level_r;
  logic [rgaa_pkg::POT_W-1:0]   out_code_r;
  logic                         out_wr_r;

  logic [rgaa_pkg::IN_W-1:0]    diff;
  logic [rgaa_pkg::PEAK_W-1:0]  pk_prod;
  logic [rgaa_pkg::LEVEL_W-1:0] pk_nxt;
  rgaa_pkg::status_t            cls;
  logic [rgaa_pkg::NUM_W-1:0]   adj_prod;
  logic [rgaa_pkg::RPROD_W-1:0] recip_prod;
  logic [rgaa_pkg::LEVEL_W-1:0] q0_nxt;
  logic [rgaa_pkg::NUM_W-1:0]   back_prod;
  logic [rgaa_pkg::NUM_W-1:0]   rem;
  logic [rgaa_pkg::LEVEL_W-1:0] quot_nxt;
  logic [13:0]                  triple;
  logic [12:0]                  half;
  logic [rgaa_pkg::LEVEL_W-1:0] lvl_nxt;

  // Peak-to-peak in mV: (max - min) * 3300 / 65536
  assign diff    = max_r - min_r;
  assign pk_prod = rgaa_pkg::PEAK_W'(diff) * rgaa_pkg::PEAK_W'(rgaa_pkg::ADC_SPAN_MV);
  assign pk_nxt  = pk_prod[rgaa_pkg::PEAK_W-1:rgaa_pkg::IN_W];

  // Classification of the captured window
  always_comb begin
    priority if (manual_r != '0) begin
      cls = rgaa_pkg::STAT_MANUAL;
    end else if (!ok_r && !force_r) begin
      cls = rgaa_pkg::STAT_NOT_PERMITTED;
    end else if (max_r < min_r) begin
      cls = rgaa_pkg::STAT_NO_INPUT;
    end else if (pk_r > rgaa_pkg::OVERLOAD_MV) begin
      cls = rgaa_pkg::STAT_OVERLOAD;
    end else if (pk_r < rgaa_pkg::NO_INPUT_MV) begin
      cls = rgaa_pkg::STAT_NO_INPUT;
    end else if (pk_r < rgaa_pkg::WINDOW_LOW_MV || pk_r > rgaa_pkg::WINDOW_HIGH_MV) begin
      cls = rgaa_pkg::STAT_ADJUSTED;
    end else begin
      cls = rgaa_pkg::STAT_IN_WINDOW;
    end
  end

  assign flags.adjust = (cls == rgaa_pkg::STAT_ADJUSTED);

  // Input seen through the current gain: numerator for the divide
  assign adj_prod = rgaa_pkg::NUM_W'(pk_r) * rgaa_pkg::NUM_W'(level_r);

  // Shared divide by 3000, step one: reciprocal multiply
  assign recip_prod = rgaa_pkg::RPROD_W'(num_r) * rgaa_pkg::RPROD_W'(rgaa_pkg::DIV_RECIP);
  assign q0_nxt     = recip_prod[rgaa_pkg::RECIP_SH+rgaa_pkg::LEVEL_W-1:rgaa_pkg::RECIP_SH];

  // Step two: one compare-and-correct
  assign back_prod = rgaa_pkg::NUM_W'(q0_r) * rgaa_pkg::DIV_MV;
  assign rem       = num_r - back_prod;
  assign quot_nxt  = q0_r + rgaa_pkg::LEVEL_W'(rem >= rgaa_pkg::DIV_MV);

  // New level: 1.5x the seen input, clamped to full
  assign triple  = 14'(quot_r) + {1'b0, quot_r, 1'b0};
  assign half    = triple[13:1];
  assign lvl_nxt = (half > 13'(rgaa_pkg::FULL_LEVEL_MV)) ? rgaa_pkg::FULL_LEVEL_MV
                                                        : half[rgaa_pkg::LEVEL_W-1:0];

  // Configuration and kept level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_r <= '0;
      level_r  <= rgaa_pkg::FULL_LEVEL_MV;
    end else begin
      if (cfg_we) begin
        manual_r <= cfg_wdata;
      end
      if (cmd.classify && cls == rgaa_pkg::STAT_OVERLOAD) begin
        level_r <= rgaa_pkg::FULL_LEVEL_MV;
      end else if (cmd.scale) begin
        level_r <= lvl_nxt;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      max_r   <= max_level;
      min_r   <= min_level;
      force_r <= force_req;
      ok_r    <= ok_to_adjust;
    end
    if (cmd.peak) begin
      pk_r <= pk_nxt;
    end
    if (cmd.classify) begin
      stat_r <= cls;
      num_r  <= adj_prod;
      if (cls == rgaa_pkg::STAT_OVERLOAD) begin
        code_r <= rgaa_pkg::FULL_POT_CODE;
        wr_r   <= 1'b1;
      end else begin
        code_r <= '0;
        wr_r   <= 1'b0;
      end
    end
    if (cmd.div_mul) begin
      q0_r <= q0_nxt;
    end
    if (cmd.div_fix) begin
      quot_r <= quot_nxt;
    end
    if (cmd.scale) begin
      num_r <= rgaa_pkg::NUM_W'({lvl_nxt, 8'b0});
      wr_r  <= (lvl_nxt != '0);
    end
    if (cmd.pot) begin
      code_r <= wr_r ? quot_r[rgaa_pkg::POT_W-1:0] : '0;
    end
    if (cmd.emit) begin
      out_status_r <= stat_r;
      out_level_r  <= level_r;
      out_code_r   <= code_r;
      out_wr_r     <= wr_r;
    end
  end

  assign status    = out_status_r;
  assign level_mv  = out_level_r;
  assign pot_code  = out_code_r;
  assign pot_write = out_wr_r;

endmodule

// ----- rtl/rgaa_ctrl.sv -----
module rgaa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rgaa_pkg::dp_flags_t flags,
  output rgaa_pkg::dp_cmd_t   cmd
);

  rgaa_pkg::ctl_state_t state_r, state_nxt;
  logic                 phase_r, phase_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgaa_pkg::CS_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands; phase 0 divides for the level, 1 for the pot code
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rgaa_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rgaa_pkg::CS_PEAK;
        end
      end
      rgaa_pkg::CS_PEAK: begin
        cmd.peak  = 1'b1;
        state_nxt = rgaa_pkg::CS_CLASS;
      end
      rgaa_pkg::CS_CLASS: begin
        cmd.classify = 1'b1;
        phase_nxt    = 1'b0;
        state_nxt    = flags.adjust ? rgaa_pkg::CS_DIV_MUL : rgaa_pkg::CS_EMIT;
      end
      rgaa_pkg::CS_DIV_MUL: begin
        cmd.div_mul = 1'b1;
        state_nxt   = rgaa_pkg::CS_DIV_FIX;
      end
      rgaa_pkg::CS_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        state_nxt   = phase_r ? rgaa_pkg::CS_POT : rgaa_pkg::CS_SCALE;
      end
      rgaa_pkg::CS_SCALE: begin
        cmd.scale = 1'b1;
        phase_nxt = 1'b1;
        state_nxt = rgaa_pkg::CS_DIV_MUL;
      end
      rgaa_pkg::CS_POT: begin
        cmd.pot   = 1'b1;
        state_nxt = rgaa_pkg::CS_EMIT;
      end
      rgaa_pkg::CS_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = rgaa_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = rgaa_pkg::CS_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_to_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == rgaa_pkg::CS_PEAK)
    else $error("accepted transfer did not start the peak step");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken output");

  a_scale_then_pot_pass: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rgaa_pkg::CS_SCALE |=> (state_r == rgaa_pkg::CS_DIV_MUL && phase_r))
    else $error("second divide pass not entered after scaling");

  a_pot_in_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rgaa_pkg::CS_POT |-> phase_r)
    else $error("pot code taken from the level divide");

endmodule

// ----- rtl/rx_gain_auto_adjust.sv -----
// After the input transfer the controller runs the peak and classify steps, then emits
// the result if the level is left alone; a rescale first makes two passes through the
// shared reciprocal divider (multiply, then correct), with scale between and pot after.
// The controller handles one item at a time; emit waits until the output register is free.
// Reset (rst_n low, synchronous): level 3000 mV, manual level 0, no result pending.
module rx_gain_auto_adjust (
  input  logic                         clk,
  input  logic                         rst_n,
  rgaa_in_if.sink                      in_ch,
  rgaa_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [rgaa_pkg::LEVEL_W-1:0] cfg_wdata
);

  rgaa_pkg::dp_cmd_t   cmd;
  rgaa_pkg::dp_flags_t flags;

  rgaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  rgaa_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .flags        (flags),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .max_level    (in_ch.max_level),
    .min_level    (in_ch.min_level),
    .force_req    (in_ch.force_req),
    .ok_to_adjust (in_ch.ok_to_adjust),
    .status       (out_ch.status),
    .level_mv     (out_ch.level_mv),
    .pot_code     (out_ch.pot_code),
    .pot_write    (out_ch.pot_write)
  );

endmodule

// ----- test/tb_rx_gain_auto_adjust.sv -----
`timescale 1ns / 1ps

module tb_rx_gain_auto_adjust;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One result of the gain loop
  typedef struct {
    rgaa_pkg::status_t                status;
    logic [rgaa_pkg::LEVEL_W-1:0]     level;
    logic [rgaa_pkg::POT_W-1:0]       pot;
    logic                             wr;
  } gain_result_t;

  // One directed row: either a register write or a measurement window
  typedef struct {
    logic                             is_cfg;
    logic [rgaa_pkg::LEVEL_W-1:0]     cfg_val;
    logic [rgaa_pkg::IN_W-1:0]        hi;
    logic [rgaa_pkg::IN_W-1:0]        lo;
    logic                             frc;
    logic                             ok;
    logic                             typed;
    gain_result_t                     res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rgaa_pkg::LEVEL_W-1:0] cfg_wdata;

  rgaa_in_if  in_ch ();
  rgaa_out_if out_ch ();

  rx_gain_auto_adjust DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic [rgaa_pkg::LEVEL_W-1:0] model_level = rgaa_pkg::FULL_LEVEL_MV;
  logic [rgaa_pkg::LEVEL_W-1:0] model_manual = '0;

  gain_result_t pending_results[$];
  gain_result_t predicted;
  gain_result_t oldest;
  logic         row_has_result = 1'b0;
  gain_result_t row_result;
  logic         failed = 1'b0;
  int unsigned  cycle_count = 0;
  stim_row_t    dir_rows[$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gain loop predictor: one window in, one result out, level updated on overload or adjustment
  function automatic gain_result_t gain_step(input logic [rgaa_pkg::IN_W-1:0] hi,
                                             input logic [rgaa_pkg::IN_W-1:0] lo,
                                             input logic frc, input logic ok);
    gain_result_t r;
    int unsigned  diff;
    int unsigned  pk;
    int unsigned  actual;
    int unsigned  lvl;
    int unsigned  pot;
    r.status = rgaa_pkg::STAT_MANUAL;
    r.pot    = '0;
    r.wr     = 1'b0;
    if (model_manual != 0) begin
      r.status = rgaa_pkg::STAT_MANUAL;
    end else if (!ok && !frc) begin
      r.status = rgaa_pkg::STAT_NOT_PERMITTED;
    end else if (hi < lo) begin
      // negative swing means nothing was seen
      r.status = rgaa_pkg::STAT_NO_INPUT;
    end else begin
      diff = 32'(hi) - 32'(lo);
      pk   = (diff * 32'(rgaa_pkg::ADC_SPAN_MV)) / 65536;
      if (pk > 32'(rgaa_pkg::OVERLOAD_MV)) begin
        model_level = rgaa_pkg::FULL_LEVEL_MV;
        r.pot       = rgaa_pkg::FULL_POT_CODE;
        r.wr        = 1'b1;
        r.status    = rgaa_pkg::STAT_OVERLOAD;
      end else if (pk < 32'(rgaa_pkg::NO_INPUT_MV)) begin
        r.status = rgaa_pkg::STAT_NO_INPUT;
      end else if (pk < 32'(rgaa_pkg::WINDOW_LOW_MV) ||
                   pk > 32'(rgaa_pkg::WINDOW_HIGH_MV)) begin
        actual = (pk * 32'(model_level)) / 32'(rgaa_pkg::FULL_LEVEL_MV);
        lvl    = (actual * 3) / 2;
        if (lvl > 32'(rgaa_pkg::FULL_LEVEL_MV)) lvl = 32'(rgaa_pkg::FULL_LEVEL_MV);
        model_level = lvl[rgaa_pkg::LEVEL_W-1:0];
        // a level of zero leaves the pot alone
        if (lvl > 0) begin
          pot   = (lvl * 256) / 32'(rgaa_pkg::FULL_LEVEL_MV);
          r.pot = pot[rgaa_pkg::POT_W-1:0];
          r.wr  = 1'b1;
        end
        r.status = rgaa_pkg::STAT_ADJUSTED;
      end else begin
        r.status = rgaa_pkg::STAT_IN_WINDOW;
      end
    end
    r.level = model_level;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Directed row builders
  function automatic stim_row_t row(input logic [rgaa_pkg::IN_W-1:0] hi,
                                    input logic [rgaa_pkg::IN_W-1:0] lo,
                                    input logic frc, input logic ok);
    stim_row_t s;
    s.is_cfg  = 1'b0;
    s.cfg_val = '0;
    s.hi      = hi;
    s.lo      = lo;
    s.frc     = frc;
    s.ok      = ok;
    s.typed   = 1'b0;
    s.res     = '{rgaa_pkg::STAT_MANUAL, '0, '0, 1'b0};
    return s;
  endfunction

  function automatic stim_row_t row_exp(input logic [rgaa_pkg::IN_W-1:0] hi,
                                        input logic [rgaa_pkg::IN_W-1:0] lo,
                                        input logic frc, input logic ok,
                                        input rgaa_pkg::status_t st,
                                        input int unsigned lvl, input int unsigned pot,
                                        input logic wr);
    stim_row_t s;
    s       = row(hi, lo, frc, ok);
    s.typed = 1'b1;
    s.res   = '{st, lvl[rgaa_pkg::LEVEL_W-1:0], pot[rgaa_pkg::POT_W-1:0], wr};
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input int unsigned v);
    stim_row_t s;
    s         = row('0, '0, 1'b0, 1'b0);
    s.is_cfg  = 1'b1;
    s.cfg_val = v[rgaa_pkg::LEVEL_W-1:0];
    return s;
  endfunction

  // Monitor: predict on input transfer, check on output transfer, watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = gain_step(in_ch.max_level, in_ch.min_level, in_ch.force_req,
                              in_ch.ok_to_adjust);
        if (row_has_result) predicted = row_result;
        pending_results.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d level %0d", $time,
                   out_ch.status, out_ch.level_mv);
          failed = 1'b1;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", 32'(oldest.status), 32'(out_ch.status));
          check_field("level_mv", 32'(oldest.level), 32'(out_ch.level_mv));
          check_field("pot_code", 32'(oldest.pot), 32'(out_ch.pot_code));
          check_field("pot_write", 32'(oldest.wr), 32'(out_ch.pot_write));
        end
      end
    end
  end

  // Receiver: stall pattern changes per segment
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned hold;
    out_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(20, 120);
      for (int unsigned i = 0; i < seg; i++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_ch.ready <= 1'b1;
          end
          1: begin
            out_ch.ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            out_ch.ready <= ((i % 7) >= 3);
          end
          default: begin
            // ready dropped at random, now and then
            hold = $urandom_range(0, 15);
            out_ch.ready <= (hold != 0);
          end
        endcase
      end
    end
  end

  task automatic idle_cycle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_cycle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write, only with nothing in flight
  task automatic write_manual(input logic [rgaa_pkg::LEVEL_W-1:0] v);
    wait_drained();
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= v;
    model_manual = v;
    @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [rgaa_pkg::IN_W-1:0] hi,
                           input logic [rgaa_pkg::IN_W-1:0] lo,
                           input logic frc, input logic ok, input logic typed,
                           input gain_result_t res);
    @(negedge clk);
    in_ch.max_level    <= hi;
    in_ch.min_level    <= lo;
    in_ch.force_req    <= frc;
    in_ch.ok_to_adjust <= ok;
    in_ch.valid        <= 1'b1;
    row_has_result = typed;
    row_result     = res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random window: negative swings, swings aimed at the interesting bands, and uniform swings
  task automatic send_random();
    int unsigned  pick;
    int unsigned  diff;
    logic [rgaa_pkg::IN_W-1:0] hi;
    logic [rgaa_pkg::IN_W-1:0] lo;
    logic         frc;
    logic         ok;
    gain_result_t none;
    none = '{rgaa_pkg::STAT_MANUAL, '0, '0, 1'b0};
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      lo = rgaa_pkg::IN_W'($urandom_range(1, 65535));
      hi = rgaa_pkg::IN_W'($urandom_range(0, 32'(lo) - 1));
    end else begin
      if (pick < 22) diff = $urandom_range(0, 900);
      else if (pick < 32) diff = $urandom_range(63400, 65535);
      else if (pick < 57) diff = $urandom_range(31600, 47800);
      else diff = $urandom_range(0, 65535);
      lo = rgaa_pkg::IN_W'($urandom_range(0, 65535 - diff));
      hi = rgaa_pkg::IN_W'(32'(lo) + diff);
    end
    if ($urandom_range(0, 9) == 0) begin
      frc = 1'b0;
      ok  = 1'b0;
    end else begin
      frc = ($urandom_range(0, 1) == 1);
      ok  = ($urandom_range(0, 1) == 1);
      if (!frc && !ok) ok = 1'b1;
    end
    send_item(hi, lo, frc, ok, 1'b0, none);
  endtask

  // Stimulus
  initial begin
    int          manual_plan[7];
    int unsigned phase_items[7];
    int unsigned sent;
    int unsigned burst;
    int          v;
    manual_plan = '{0, 3000, 0, 1, 0, -1, 0};
    phase_items = '{420, 25, 420, 25, 400, 25, 400};

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.max_level    = '0;
    in_ch.min_level    = '0;
    in_ch.force_req    = 1'b0;
    in_ch.ok_to_adjust = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: band edges, overload, negative swing, collapse to zero, manual
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(row_exp(16'd0, 16'd0, 1'b0, 1'b0, rgaa_pkg::STAT_NOT_PERMITTED,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'hFFFF, 16'd0, 1'b0, 1'b1, rgaa_pkg::STAT_OVERLOAD,
                               3000, 256, 1'b1));
    dir_rows.push_back(row_exp(16'd0, 16'hFFFF, 1'b1, 1'b0, rgaa_pkg::STAT_NO_INPUT,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd0, 16'd0, 1'b1, 1'b1, rgaa_pkg::STAT_NO_INPUT,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd794, 16'd0, 1'b0, 1'b1, rgaa_pkg::STAT_NO_INPUT,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd40000, 16'd281, 1'b0, 1'b1, rgaa_pkg::STAT_IN_WINDOW,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd31776, 16'd0, 1'b0, 1'b1, rgaa_pkg::STAT_IN_WINDOW,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd47663, 16'd0, 1'b1, 1'b1, rgaa_pkg::STAT_IN_WINDOW,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'hFFFF, 16'd1965, 1'b0, 1'b1, rgaa_pkg::STAT_OVERLOAD,
                               3000, 256, 1'b1));
    dir_rows.push_back(row(16'd63551, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(row(16'd47683, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(row(16'd31775, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(row(16'd795, 16'd0, 1'b1, 1'b0));
    dir_rows.push_back(row(16'd795, 16'd0, 1'b1, 1'b1));
    dir_rows.push_back(row(16'd795, 16'd0, 1'b0, 1'b1));
    dir_rows.push_back(row_exp(16'hFFFF, 16'd0, 1'b1, 1'b0, rgaa_pkg::STAT_OVERLOAD,
                               3000, 256, 1'b1));
    dir_rows.push_back(cfg_row(3000));
    dir_rows.push_back(row_exp(16'hFFFF, 16'd0, 1'b1, 1'b1, rgaa_pkg::STAT_MANUAL,
                               3000, 0, 1'b0));
    dir_rows.push_back(row_exp(16'd0, 16'hFFFF, 1'b0, 1'b0, rgaa_pkg::STAT_MANUAL,
                               3000, 0, 1'b0));
    dir_rows.push_back(cfg_row(1));
    dir_rows.push_back(row_exp(16'd40000, 16'd281, 1'b1, 1'b1, rgaa_pkg::STAT_MANUAL,
                               3000, 0, 1'b0));
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(row_exp(16'hFFFF, 16'hFFFE, 1'b1, 1'b1, rgaa_pkg::STAT_NO_INPUT,
                               3000, 0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_manual(dir_rows[i].cfg_val);
      end else begin
        send_item(dir_rows[i].hi, dir_rows[i].lo, dir_rows[i].frc, dir_rows[i].ok,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases across manual settings
    for (int p = 0; p < 7; p++) begin
      v = manual_plan[p];
      if (v < 0) v = $urandom_range(2, 2999);
      write_manual(v[rgaa_pkg::LEVEL_W-1:0]);
      sent = 0;
      while (sent < phase_items[p]) begin
        burst = $urandom_range(1, 24);
        for (int unsigned b = 0; b < burst && sent < phase_items[p]; b++) begin
          send_random();
          sent++;
        end
        // gaps between bursts, sometimes none, sometimes a full drain
        if ($urandom_range(0, 30) == 0) begin
          wait_drained();
        end else if ($urandom_range(0, 3) != 0) begin
          repeat ($urandom_range(1, 10)) idle_cycle();
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rgaa_pkg.sv
rtl/rgaa_in_if.sv
rtl/rgaa_out_if.sv
rtl/rgaa_datapath.sv
rtl/rgaa_ctrl.sv
rtl/rx_gain_auto_adjust.sv
test/tb_rx_gain_auto_adjust.sv
